/* design/sync_length_xor_frame_receiver_macros.svh */
// assertion macros used by the frame receiver checker
`ifndef SYNC_LENGTH_XOR_FRAME_RECEIVER_MACROS_SVH
`define SYNC_LENGTH_XOR_FRAME_RECEIVER_MACROS_SVH

// implication in the same cycle, sampled on clk_i, off while rst_ni is low
`define SLXFR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// implication into the next cycle, sampled on clk_i, off while rst_ni is low
`define SLXFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/slxfr_pkg.sv */
// shared types and constants of the sync/length/xor frame receiver
package slxfr_pkg;

  // sync pair that opens every frame
  localparam logic [7:0] SYNC_FIRST  = 8'hEB;
  localparam logic [7:0] SYNC_SECOND = 8'h53;

  // width of the packed result word
  localparam int unsigned OUT_DATA_W = 48;

  // result kinds
  typedef enum logic [1:0] {
    KIND_PAYLOAD  = 2'd0,
    KIND_ACCEPT   = 2'd1,
    KIND_MISMATCH = 2'd2,
    KIND_OVERFLOW = 2'd3
  } kind_e;

  // input word held between the slave port and the parser
  typedef struct packed {
    logic       valid;
    logic [7:0] rx_byte;
  } in_word_t;

  // one result word
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data_byte;
    logic [11:0] byte_index;
    logic [15:0] frame_length;
    logic [7:0]  first_byte;
  } res_t;

endpackage

/* design/slxfr_in_reg.sv */
// input register stage of the frame receiver
module slxfr_in_reg
  import slxfr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,
  input  logic       advance_i,
  output in_word_t   word_o
);

  logic       valid_q;
  logic [7:0] byte_q;
  logic       accept;

  // free when empty or when the held word moves on this cycle
  assign s_axis_tready_o = !valid_q || advance_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (advance_i) begin
      valid_q <= 1'b0;
    end
  end

  // held byte
  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= s_axis_tdata_i;
    end
  end

  assign word_o.valid   = valid_q;
  assign word_o.rx_byte = byte_q;

endmodule

/* design/slxfr_parser.sv */
// frame parser: phase state, length, running xor and result selection
module slxfr_parser
  import slxfr_pkg::*;
#(
  parameter int unsigned BUF_DEPTH = 4096
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  in_word_t word_i,
  input  logic     advance_i,
  output logic     res_valid_o,
  output res_t     res_o
);

  localparam int unsigned CNT_W = $clog2(BUF_DEPTH + 1);

  typedef enum logic [4:0] {
    PH_HUNT   = 5'b00001,
    PH_SYNC2  = 5'b00010,
    PH_LEN_LO = 5'b00100,
    PH_LEN_HI = 5'b01000,
    PH_BODY   = 5'b10000
  } phase_e;

  phase_e             phase_q, phase_d;
  logic [7:0]         xor_q, xor_d;
  logic [15:0]        len_q, len_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [7:0]         cmd_q, cmd_d;
  logic               proc_en;
  logic [7:0]         b;
  logic [31:0]        cnt_ext;
  logic [7:0]         cmd_now;

  assign proc_en = word_i.valid && advance_i;
  assign b       = word_i.rx_byte;
  assign cnt_ext = 32'(cnt_q);
  assign cmd_now = (cnt_q == '0) ? b : cmd_q;

  // next state and result for the byte in the input register
  always_comb begin
    phase_d            = phase_q;
    xor_d              = xor_q;
    len_d              = len_q;
    cnt_d              = cnt_q;
    cmd_d              = cmd_q;
    res_valid_o        = 1'b0;
    res_o.kind         = KIND_PAYLOAD;
    res_o.data_byte    = b;
    res_o.byte_index   = '0;
    res_o.frame_length = len_q;
    res_o.first_byte   = '0;
    case (phase_q)
      PH_HUNT: begin
        if (b == SYNC_FIRST) begin
          phase_d = PH_SYNC2;
        end else begin
          xor_d = '0;
          cnt_d = '0;
        end
      end
      PH_SYNC2: begin
        cnt_d = '0;
        if (b == SYNC_SECOND) begin
          phase_d = PH_LEN_LO;
        end else begin
          phase_d = PH_HUNT;
          xor_d   = '0;
        end
      end
      PH_LEN_LO: begin
        len_d   = {8'h00, b};
        phase_d = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        len_d   = {b, len_q[7:0]};
        phase_d = PH_BODY;
      end
      PH_BODY: begin
        res_valid_o = 1'b1;
        if (cnt_ext >= BUF_DEPTH) begin
          // buffer full: drop the byte and abort the frame
          res_o.kind       = KIND_OVERFLOW;
          res_o.first_byte = cmd_q;
          phase_d          = PH_HUNT;
          xor_d            = '0;
          cnt_d            = '0;
        end else if (cnt_ext >= 32'(len_q)) begin
          // checksum byte
          cmd_d            = cmd_now;
          res_o.kind       = (xor_q == b) ? KIND_ACCEPT : KIND_MISMATCH;
          res_o.first_byte = cmd_now;
          phase_d          = PH_HUNT;
          xor_d            = '0;
          cnt_d            = '0;
        end else begin
          // payload byte
          cmd_d            = cmd_now;
          res_o.byte_index = cnt_ext[11:0];
          cnt_d            = cnt_q + CNT_W'(1);
          xor_d            = xor_q ^ b;
        end
      end
      default: begin
        phase_d = PH_HUNT;
        xor_d   = '0;
        cnt_d   = '0;
      end
    endcase
    if (!proc_en) begin
      res_valid_o = 1'b0;
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      xor_q   <= '0;
      len_q   <= '0;
      cnt_q   <= '0;
      cmd_q   <= '0;
    end else if (proc_en) begin
      phase_q <= phase_d;
      xor_q   <= xor_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      cmd_q   <= cmd_d;
    end
  end

endmodule

/* design/slxfr_out_reg.sv */
// result register stage of the frame receiver
module slxfr_out_reg
  import slxfr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic res_valid_i,
  input  res_t res_i,
  input  logic m_axis_tready_i,
  output logic m_axis_tvalid_o,
  output res_t res_o,
  output logic advance_o
);

  logic valid_q;
  res_t res_q;

  // the pipe moves when the result register is empty or being taken
  assign advance_o = !valid_q || m_axis_tready_i;

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_o) begin
      valid_q <= res_valid_i;
    end
  end

  // result word
  always_ff @(posedge clk_i) begin
    if (advance_o && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign m_axis_tvalid_o = valid_q;
  assign res_o           = res_q;

endmodule

/* design/sync_length_xor_frame_receiver.sv */
// top level of the sync/length/xor serial frame receiver
//
//  channel  dir  tdata fields (low bit up)                         tuser
//  s_axis   in   rx_byte[7:0]                                      -
//  m_axis   out  data_byte[7:0] byte_index[19:8] frame_length[35:20]
//                first_byte[43:36] zero[47:44]                      kind[1:0]
//
// one byte is taken every cycle while m_axis does not stall; the byte is held in
// the input register and its result word in the result register, which drives m_axis
// rst_ni clears the parser to the hunt for the first sync byte
// a stall on m_axis with a result waiting holds the result and input registers;
// s_axis_tready_o drops in that same cycle once the input register holds a word
module sync_length_xor_frame_receiver
  import slxfr_pkg::*;
#(
  parameter int unsigned BUF_DEPTH = 4096
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [7:0]            s_axis_tdata_i,  // rx_byte[7:0]
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // data_byte[7:0], byte_index[19:8], frame_length[35:20], first_byte[43:36], zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  output logic [1:0]            m_axis_tuser_o   // kind[1:0]
);

  in_word_t in_word;
  logic     advance;
  logic     res_valid;
  res_t     res;
  res_t     out_res;

  slxfr_in_reg u_in_reg (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .advance_i       (advance),
    .word_o          (in_word)
  );

  slxfr_parser #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .word_i      (in_word),
    .advance_i   (advance),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  slxfr_out_reg u_out_reg (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .res_valid_i     (res_valid),
    .res_i           (res),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .res_o           (out_res),
    .advance_o       (advance)
  );

  // pack the result word
  assign m_axis_tdata_o = {4'h0, out_res.first_byte, out_res.frame_length,
                           out_res.byte_index, out_res.data_byte};
  assign m_axis_tuser_o = out_res.kind;

endmodule

/* design/slxfr_checker.sv */
// port-level checks of the frame receiver and their bind
`include "sync_length_xor_frame_receiver_macros.svh"

module slxfr_checker
  import slxfr_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  m_axis_tvalid_o,
  input logic                  m_axis_tready_i,
  input logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  input logic [1:0]            m_axis_tuser_o
);

  // a stalled result word holds
  `SLXFR_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i,
    m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o),
    "stalled result word changed")

  // payload words carry no command byte
  `SLXFR_ASSERT_NOW(a_payload_first, m_axis_tvalid_o && (m_axis_tuser_o == KIND_PAYLOAD),
    m_axis_tdata_o[43:36] == 8'h00, "payload word with nonzero first_byte")

  // status words carry index zero
  `SLXFR_ASSERT_NOW(a_status_index, m_axis_tvalid_o && (m_axis_tuser_o != KIND_PAYLOAD),
    m_axis_tdata_o[19:8] == 12'h000, "status word with nonzero byte_index")

  // padding bits stay clear
  `SLXFR_ASSERT_NOW(a_pad_zero, m_axis_tvalid_o, m_axis_tdata_o[47:44] == 4'h0,
    "result padding not zero")

endmodule

bind sync_length_xor_frame_receiver slxfr_checker u_slxfr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

/* tb/sync_length_xor_frame_receiver_test.sv */
// self-checking testbench of the sync/length/xor serial frame receiver
module sync_length_xor_frame_receiver_test;
  import slxfr_pkg::*;

  localparam int unsigned RX_BUF_DEPTH = 4096;

  // parser phases as the block walks through a frame
  typedef enum logic [2:0] {
    RX_HUNT   = 3'd0,
    RX_SYNC2  = 3'd1,
    RX_LEN_LO = 3'd2,
    RX_LEN_HI = 3'd3,
    RX_BODY   = 3'd4
  } rx_phase_e;

  // deframing predictor and store of expected result words
  class frame_predictor;
    rx_phase_e   phase;
    logic [7:0]  running_xor;
    logic [15:0] declared_len;
    logic [12:0] bytes_taken;
    logic [7:0]  command_byte;
    res_t        expected_words[$];
    int          n_errors;
    int          n_payload;
    int          n_accept;
    int          n_mismatch;
    int          n_overflow;

    function new();
      phase        = RX_HUNT;
      running_xor  = '0;
      declared_len = '0;
      bytes_taken  = '0;
      command_byte = '0;
      n_errors     = 0;
      n_payload    = 0;
      n_accept     = 0;
      n_mismatch   = 0;
      n_overflow   = 0;
    endfunction

    // length and command byte survive the return to the hunt
    function void restart_hunt();
      phase       = RX_HUNT;
      running_xor = '0;
      bytes_taken = '0;
    endfunction

    function void push_word(kind_e k, logic [7:0] d, logic [11:0] idx, logic [7:0] first);
      res_t w;
      w.kind         = k;
      w.data_byte    = d;
      w.byte_index   = idx;
      w.frame_length = declared_len;
      w.first_byte   = first;
      expected_words.push_back(w);
    endfunction

    // note one accepted rx word and queue any result it causes
    function void note_rx_byte(logic [7:0] b);
      kind_e status;
      case (phase)
        RX_HUNT: begin
          if (b == SYNC_FIRST) phase = RX_SYNC2;
          else restart_hunt();
        end
        RX_SYNC2: begin
          if (b == SYNC_SECOND) begin
            phase       = RX_LEN_LO;
            bytes_taken = '0;
          end else begin
            restart_hunt();
          end
        end
        RX_LEN_LO: begin
          declared_len = {8'h00, b};
          phase        = RX_LEN_HI;
        end
        RX_LEN_HI: begin
          declared_len[15:8] = b;
          phase              = RX_BODY;
        end
        RX_BODY: begin
          if (int'(bytes_taken) >= RX_BUF_DEPTH) begin
            // buffer full, the byte is dropped
            push_word(KIND_OVERFLOW, b, '0, command_byte);
            restart_hunt();
          end else begin
            if (bytes_taken == '0) command_byte = b;
            bytes_taken++;
            if (int'(bytes_taken) >= int'(declared_len) + 1) begin
              // checksum byte closes the frame
              status = (running_xor == b) ? KIND_ACCEPT : KIND_MISMATCH;
              push_word(status, b, '0, command_byte);
              restart_hunt();
            end else begin
              push_word(KIND_PAYLOAD, b, 12'(bytes_taken - 13'd1), 8'h00);
              running_xor ^= b;
            end
          end
        end
        default: restart_hunt();
      endcase
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    // one line per mismatch, and count it
    function void report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      n_errors++;
    endfunction

    // compare a result word with the oldest expectation
    function void check_word(res_t got);
      res_t exp_w;
      if (expected_words.size() == 0) begin
        report($sformatf("unexpected word kind=%s data=%02h idx=%0d len=%0d first=%02h",
                         got.kind.name(), got.data_byte, got.byte_index,
                         got.frame_length, got.first_byte));
        return;
      end
      exp_w = expected_words.pop_front();
      if (got.kind != exp_w.kind || got.data_byte != exp_w.data_byte ||
          got.byte_index != exp_w.byte_index || got.frame_length != exp_w.frame_length ||
          got.first_byte != exp_w.first_byte) begin
        report($sformatf({"got kind=%0d data=%02h idx=%0d len=%0d first=%02h, ",
                          "want kind=%0d data=%02h idx=%0d len=%0d first=%02h"},
                         got.kind, got.data_byte, got.byte_index, got.frame_length,
                         got.first_byte, exp_w.kind, exp_w.data_byte, exp_w.byte_index,
                         exp_w.frame_length, exp_w.first_byte));
      end
      case (exp_w.kind)
        KIND_PAYLOAD:  n_payload++;
        KIND_ACCEPT:   n_accept++;
        KIND_MISMATCH: n_mismatch++;
        default:       n_overflow++;
      endcase
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [7:0]            s_axis_tdata_i = 8'h00;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic [1:0]            m_axis_tuser_o;

  frame_predictor pred;
  int idle_pct  = 0;
  int stall_pct = 0;
  int rx_words  = 0;
  int framed_words = 0;

  sync_length_xor_frame_receiver #(
    .BUF_DEPTH(RX_BUF_DEPTH)
  ) i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o,
    .m_axis_tuser_o
  );

  // clock
  always #10 clk_i = ~clk_i;

  // receiver back-pressure
  always @(negedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= stall_pct);
  end

  // result monitor
  always @(posedge clk_i) begin
    res_t got;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.kind         = kind_e'(m_axis_tuser_o);
      got.data_byte    = m_axis_tdata_o[7:0];
      got.byte_index   = m_axis_tdata_o[19:8];
      got.frame_length = m_axis_tdata_o[35:20];
      got.first_byte   = m_axis_tdata_o[43:36];
      pred.check_word(got);
    end
  end

  // drive one rx word with random sender gaps ahead of it
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    do @(posedge clk_i); while (!s_axis_tready_o);
    pred.note_rx_byte(b);
    rx_words++;
  endtask

  // one frame, optionally with a bad checksum or cut short
  task automatic send_frame(input int len, input bit bad_sum, input bit cut_short);
    logic [7:0] sum;
    logic [7:0] b;
    int         n_body;
    sum    = 8'h00;
    n_body = cut_short ? $urandom_range(len) : len;
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    send_byte(len[7:0]);
    send_byte(len[15:8]);
    for (int i = 0; i < n_body; i++) begin
      b = 8'($urandom_range(255));
      sum ^= b;
      send_byte(b);
    end
    if (!cut_short) send_byte(bad_sum ? sum ^ 8'($urandom_range(1, 255)) : sum);
    framed_words += n_body + 5;
  endtask

  // mostly well-formed frames, some noise and broken sync sequences
  task automatic run_random_part(input int target);
    int   start;
    int   r;
    int   len;
    logic [7:0] b;
    start = framed_words;
    while (framed_words - start < target) begin
      r = $urandom_range(99);
      len = $urandom_range(99);
      if (len < 85) len = $urandom_range(12);
      else if (len < 98) len = $urandom_range(13, 48);
      else len = 256 + $urandom_range(8);
      if (r < 72) begin
        send_frame(len, $urandom_range(99) < 25, 1'b0);
      end else if (r < 80) begin
        send_frame(len, 1'b0, 1'b1);
      end else if (r < 90) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)));
      end else if (r < 96) begin
        b = 8'($urandom_range(255));
        if (b == SYNC_SECOND) b = ~b;
        send_byte(SYNC_FIRST);
        send_byte(b);
      end else begin
        // repeated first sync byte does not count as a new start
        send_byte(SYNC_FIRST);
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
      end
    end
  endtask

  // stimulus and end of run
  initial begin
    logic [7:0] directed[$];
    int idle_tab[4];
    int stall_tab[4];
    int guard;
    idle_tab  = '{0, 57, 0, 15};
    stall_tab = '{0, 0, 57, 15};
    pred = new();
    // noise, broken syncs, empty frames, short frames with good and bad sums
    directed = '{8'h00, 8'hFF, SYNC_FIRST, 8'h00, SYNC_FIRST, SYNC_FIRST, SYNC_SECOND,
                 SYNC_FIRST, SYNC_SECOND, 8'h00, 8'h00, 8'h00,
                 SYNC_FIRST, SYNC_SECOND, 8'h00, 8'h00, 8'hFF,
                 SYNC_FIRST, SYNC_SECOND, 8'h03, 8'h00, 8'hFF, 8'h00, SYNC_FIRST, 8'h14,
                 SYNC_FIRST, SYNC_SECOND, 8'h01, 8'h00, SYNC_SECOND, 8'h00};
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed[i]) send_byte(directed[i]);

    for (int p = 0; p < 4; p++) begin
      idle_pct  = idle_tab[p];
      stall_pct = stall_tab[p];
      run_random_part(220);
    end
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;

    // drain outstanding results
    guard = 0;
    while (pred.pending() > 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    if (pred.pending() > 0)
      pred.report($sformatf("%0d expected words never arrived", pred.pending()));
    repeat (10) @(posedge clk_i);

    $display("run covered %0d rx words under four sender/receiver idle mixes", rx_words);
    $display("results: %0d payload, %0d accepted, %0d mismatch, %0d overflow, %0d errors",
             pred.n_payload, pred.n_accept, pred.n_mismatch, pred.n_overflow,
             pred.n_errors);
    if (pred.n_errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  // watchdog
  initial begin
    #8000000;
    $display("timeout: run did not complete");
    $display("== FAIL ==");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+design
design/slxfr_pkg.sv
design/slxfr_in_reg.sv
design/slxfr_parser.sv
design/slxfr_out_reg.sv
design/sync_length_xor_frame_receiver.sv
design/slxfr_checker.sv
tb/sync_length_xor_frame_receiver_test.sv
